### hdl/crtc_pkg.sv
`timescale 1ns / 1ps

package crtc_pkg;

    // Number of implemented data registers (18 to 32)
    localparam int REGISTER_COUNT = 18;
    localparam int REG_IDX_W      = $clog2(REGISTER_COUNT);
    localparam int BASE_REGS      = 18;
    localparam int HARDWIRED_REGS = 9;

    // Commands carried in s_tuser[1:0]
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Port select carried in s_tuser[2]
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    // Event codes carried in m_tuser
    localparam logic [2:0] EV_QUIET    = 3'd0;
    localparam logic [2:0] EV_INDEX    = 3'd1;
    localparam logic [2:0] EV_CURSOR   = 3'd2;
    localparam logic [2:0] EV_REFRESH  = 3'd3;
    localparam logic [2:0] EV_REJECTED = 3'd4;

    // Cursor mode field of register 10
    localparam logic [7:0] CURSOR_MODE_MASK  = 8'h60;
    localparam logic [7:0] CURSOR_MODE_ON    = 8'h00;
    localparam logic [7:0] CURSOR_MODE_OFF   = 8'h20;
    localparam logic [7:0] CURSOR_MODE_FAST  = 8'h40;
    localparam logic [7:0] CURSOR_MODE_SLOW  = 8'h60;

    localparam logic [7:0] OUT_OF_RANGE_READ = 8'hFF;

    localparam logic [7:0] HARDWIRED [HARDWIRED_REGS] = '{
        8'd113, 8'd80, 8'd90, 8'd10, 8'd127, 8'd6, 8'd100, 8'd112, 8'd2
    };

    localparam logic [7:0] STORE_MASK_FULL [BASE_REGS] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h1F, 8'h7F, 8'h7F, 8'h3F,
        8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'hFF, 8'hFF
    };

    localparam logic [7:0] STORE_MASK_REDUCED [BASE_REGS] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'hFF, 8'hFF
    };

    localparam logic [7:0] READ_MASK [BASE_REGS] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'h3F, 8'hFF
    };

    function automatic logic [7:0] write_bits(input logic chip, input logic [4:0] n);
        logic [7:0] m;
        if (n < 5'(BASE_REGS)) begin
            m = chip ? STORE_MASK_REDUCED[n] : STORE_MASK_FULL[n];
        end else begin
            m = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic [7:0] readable_bits(input logic [4:0] n);
        logic [7:0] m;
        if (n < 5'(BASE_REGS)) begin
            m = READ_MASK[n];
        end else begin
            m = 8'hFF;
        end
        return m;
    endfunction

endpackage

### hdl/crt_controller_register_file_core.sv
`timescale 1ns / 1ps

// Indexed CRT controller register file with a stream front end. Each beat on
// the slave side is a bus read, a bus write or a blink tick (s_tuser), and
// produces exactly one registered result beat carrying the read byte,
// an event code and the cursor state and display geometry as they stand
// after the beat. One beat is taken every cycle unless the result is stalled:
// the register update and all derived fields are a single pass of short logic
// into the result register, and the slave side stays ready while that register
// is empty or being drained, so throughput is one beat per clock.
// chip_type is set through cfg_we/cfg_wdata; in the reduced variant registers
// 0 to 8 ignore writes and supply fixed defaults to the derived fields.
module crt_controller_register_file_core
    import crtc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [0:0]  cfg_wdata,      // chip_type

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] write_data
    input  logic [2:0]  s_tuser,        // [1:0] command, [2] port_select

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] cursor_visible, [22:9] cursor_address,
    // [27:23] cursor_top_line, [32:28] cursor_bottom_line,
    // [40:33] char_columns, [46:41] char_height, [53:47] char_rows,
    // [67:54] start_address, [77:68] hsync_distance,
    // [86:78] vsync_distance, [87] zero
    output logic [87:0] m_tdata,
    output logic [2:0]  m_tuser         // [2:0] event_status
);

    logic        chip_reg;
    logic [7:0]  index_reg, index_next;
    logic [1:0]  blink_cnt_reg, blink_cnt_next;
    logic        blink_phase_reg, blink_phase_next;
    logic [7:0]  store_reg  [REGISTER_COUNT];
    logic [7:0]  store_next [REGISTER_COUNT];

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    logic        accept;
    logic [1:0]  command;
    logic        port_sel;
    logic [7:0]  wdata;
    logic [4:0]  n;
    logic        n_valid;
    logic [7:0]  cur_val;
    logic [7:0]  mask;
    logic [7:0]  rd_data;
    logic [7:0]  mode;
    logic [2:0]  blink_sum;
    logic [1:0]  blink_limit;

    logic [7:0]  view [16];
    logic        cursor_visible;
    logic [13:0] cursor_address;
    logic [13:0] start_address;
    logic [5:0]  char_height;
    logic [9:0]  hsync_distance;
    logic [8:0]  vsync_distance;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign command  = s_tuser[1:0];
    assign port_sel = s_tuser[2];
    assign wdata    = s_tdata;
    assign n        = index_reg[4:0];
    assign n_valid  = ({1'b0, n} < 6'(REGISTER_COUNT));
    assign mask     = write_bits(chip_reg, n);

    always_comb begin
        if (chip_reg && n < 5'(HARDWIRED_REGS)) begin
            cur_val = HARDWIRED[n[3:0]];
        end else begin
            cur_val = store_reg[n[REG_IDX_W-1:0]];
        end
    end

    // State update for one beat
    always_comb begin
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            store_next[i] = store_reg[i];
        end
        index_next       = index_reg;
        blink_cnt_next   = blink_cnt_reg;
        blink_phase_next = blink_phase_reg;
        rd_data          = 8'h00;
        m_tuser_next     = EV_QUIET;
        mode             = store_reg[10] & CURSOR_MODE_MASK;
        blink_limit      = (mode == CURSOR_MODE_SLOW) ? 2'd2 : 2'd1;
        blink_sum        = {1'b0, blink_cnt_reg} + 3'd1;

        case (command)
            CMD_READ: begin
                if (port_sel == PORT_INDEX) begin
                    rd_data = index_reg;
                end else if (n_valid) begin
                    rd_data = cur_val & readable_bits(n);
                end else begin
                    rd_data = OUT_OF_RANGE_READ;
                end
            end
            CMD_WRITE: begin
                if (port_sel == PORT_INDEX) begin
                    index_next   = wdata;
                    m_tuser_next = EV_INDEX;
                end else if (!n_valid) begin
                    m_tuser_next = EV_REJECTED;
                end else begin
                    store_next[n[REG_IDX_W-1:0]] =
                        (store_reg[n[REG_IDX_W-1:0]] & ~mask) | (wdata & mask);
                    if (n == 5'd10 || n == 5'd11 || n == 5'd14 || n == 5'd15) begin
                        m_tuser_next = EV_CURSOR;
                    end else begin
                        m_tuser_next = EV_REFRESH;
                    end
                end
            end
            CMD_TICK: begin
                // wrap past the mode's limit and flip the blink phase
                if (blink_sum > {1'b0, blink_limit}) begin
                    blink_cnt_next   = 2'd0;
                    blink_phase_next = !blink_phase_reg;
                end else begin
                    blink_cnt_next   = blink_sum[1:0];
                end
                m_tuser_next = EV_CURSOR;
            end
            default: begin
                m_tuser_next = EV_QUIET;
            end
        endcase
    end

    // Register view after the beat, hardwired defaults applied
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            if (chip_reg && k < HARDWIRED_REGS) begin
                view[k] = HARDWIRED[4'(k)];
            end else begin
                view[k] = store_next[k];
            end
        end
    end

    always_comb begin
        case (view[10] & CURSOR_MODE_MASK)
            CURSOR_MODE_ON:   cursor_visible = 1'b1;
            CURSOR_MODE_OFF:  cursor_visible = 1'b0;
            CURSOR_MODE_FAST: cursor_visible = blink_phase_next;
            CURSOR_MODE_SLOW: cursor_visible = blink_phase_next;
            default:          cursor_visible = 1'b1;
        endcase
    end

    assign cursor_address = {view[14][5:0], view[15]};
    assign start_address  = {view[12][5:0], view[13]};
    assign char_height    = {1'b0, view[9][4:0]} + 6'd1;
    assign hsync_distance = {2'b00, view[0]} + 10'd1 - {2'b00, view[2]};
    assign vsync_distance = {1'b0, view[4]} + 9'd1 - {1'b0, view[7]};

    assign m_tdata_next = {
        1'b0,
        vsync_distance,
        hsync_distance,
        start_address,
        view[6][6:0],
        char_height,
        view[1],
        view[11][4:0],
        view[10][4:0],
        cursor_address,
        cursor_visible,
        rd_data
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chip_reg        <= 1'b0;
            index_reg       <= 8'h00;
            blink_cnt_reg   <= 2'd0;
            blink_phase_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                store_reg[i] <= 8'h00;
            end
        end else begin
            if (cfg_we) begin
                chip_reg <= cfg_wdata[0];
            end
            if (accept) begin
                index_reg       <= index_next;
                blink_cnt_reg   <= blink_cnt_next;
                blink_phase_reg <= blink_phase_next;
                for (int i = 0; i < REGISTER_COUNT; i++) begin
                    store_reg[i] <= store_next[i];
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

endmodule

### hdl/crtc_checker.sv
`timescale 1ns / 1ps

module crtc_checker
    import crtc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_index_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[1:0] == CMD_WRITE && s_tuser[2] == PORT_INDEX
        |=> m_tvalid && m_tuser == EV_INDEX)
        else $error("index write did not report index event");

    a_tick_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[1:0] == CMD_TICK
        |=> m_tvalid && m_tuser == EV_CURSOR)
        else $error("blink tick did not report cursor event");

    a_quiet_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_QUIET |-> m_tdata[7:0] == 8'h00)
        else $error("read data non-zero on a non-read beat");

    a_height: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[46:41] != 6'd0)
        else $error("character height of zero");

endmodule

bind crt_controller_register_file_core crtc_checker u_crtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/crt_controller_register_file_core_tb.sv
`timescale 1ns / 1ps

module crt_controller_register_file_core_tb;
    import crtc_pkg::*;

    // Command code that the block must treat as a no-op
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Register indexes used by the geometry and cursor fields
    localparam int R_HTOTAL  = 0;
    localparam int R_HDISP   = 1;
    localparam int R_HSYNC   = 2;
    localparam int R_VTOTAL  = 4;
    localparam int R_VDISP   = 6;
    localparam int R_VSYNC   = 7;
    localparam int R_MAXSCAN = 9;
    localparam int R_CSTART  = 10;
    localparam int R_CEND    = 11;
    localparam int R_SA_HI   = 12;
    localparam int R_SA_LO   = 13;
    localparam int R_CA_HI   = 14;
    localparam int R_CA_LO   = 15;
    localparam int R_LAST    = 17;
    localparam int FIXED_COUNT = 9;
    localparam int MASKED_REGS = 18;

    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [7:0] FIXED_REGS [FIXED_COUNT] = '{
        8'd113, 8'd80, 8'd90, 8'd10, 8'd127, 8'd6, 8'd100, 8'd112, 8'd2
    };
    localparam logic [7:0] KEEP_FULL [MASKED_REGS] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h1F, 8'h7F, 8'h7F, 8'h3F,
        8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'hFF, 8'hFF
    };
    localparam logic [7:0] KEEP_REDUCED [MASKED_REGS] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'hFF, 8'hFF
    };
    localparam logic [7:0] VIEW_MASK [MASKED_REGS] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'h3F, 8'hFF
    };

    typedef struct {
        logic [1:0] cmd;
        logic       port;
        logic [7:0] data;
    } bus_access_t;

    typedef struct {
        logic [7:0]  read_data;
        logic [2:0]  event_status;
        logic        cursor_visible;
        logic [13:0] cursor_address;
        logic [4:0]  cursor_top_line;
        logic [4:0]  cursor_bottom_line;
        logic [7:0]  char_columns;
        logic [5:0]  char_height;
        logic [6:0]  char_rows;
        logic [13:0] start_address;
        logic [9:0]  hsync_distance;
        logic [8:0]  vsync_distance;
        logic        pad;
    } crtc_status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [2:0]  s_tuser = 3'b000;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;

    // Shadow of the block's state
    logic [7:0] reg_copy [32] = '{default: 8'h00};
    logic [7:0] index_copy = 8'h00;
    logic [1:0] blink_count = 2'd0;
    logic       blink_phase = 1'b0;
    logic       chip_copy = 1'b0;

    bus_access_t  access_q [$];
    crtc_status_t status_q [$];

    int send_idle_pct = 30;
    int recv_idle_pct = 84;
    int fail_count = 0;
    int stall_cycles = 0;

    crt_controller_register_file_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    function automatic logic [7:0] reg_view(input int n);
        logic [7:0] v;
        v = 8'h00;
        if (n < REGISTER_COUNT) begin
            if (chip_copy && n < FIXED_COUNT) begin
                v = FIXED_REGS[n];
            end else begin
                v = reg_copy[n];
            end
        end
        return v;
    endfunction

    function automatic crtc_status_t predict_status(input bus_access_t a);
        crtc_status_t r;
        int n;
        int lim;
        int cnt;
        int h;
        int v;
        logic [7:0] keep;
        logic [7:0] mode;
        logic [15:0] wide;
        n = int'(index_copy[4:0]);
        r.read_data = 8'h00;
        r.event_status = EV_QUIET;
        case (a.cmd)
            CMD_READ: begin
                if (a.port == PORT_INDEX) begin
                    r.read_data = index_copy;
                end else if (n < REGISTER_COUNT) begin
                    r.read_data = reg_view(n) & ((n < MASKED_REGS) ? VIEW_MASK[n] : 8'hFF);
                end else begin
                    r.read_data = 8'hFF;
                end
            end
            CMD_WRITE: begin
                if (a.port == PORT_INDEX) begin
                    index_copy = a.data;
                    r.event_status = EV_INDEX;
                end else if (n >= REGISTER_COUNT) begin
                    r.event_status = EV_REJECTED;
                end else begin
                    if (n < MASKED_REGS) begin
                        keep = chip_copy ? KEEP_REDUCED[n] : KEEP_FULL[n];
                    end else begin
                        keep = 8'hFF;
                    end
                    reg_copy[n] = (reg_copy[n] & ~keep) | (a.data & keep);
                    if (n == R_CSTART || n == R_CEND || n == R_CA_HI || n == R_CA_LO) begin
                        r.event_status = EV_CURSOR;
                    end else begin
                        r.event_status = EV_REFRESH;
                    end
                end
            end
            CMD_TICK: begin
                lim = ((reg_view(R_CSTART) & CURSOR_MODE_MASK) == CURSOR_MODE_SLOW) ? 2 : 1;
                cnt = int'(blink_count) + 1;
                if (cnt > lim) begin
                    cnt = 0;
                    blink_phase = ~blink_phase;
                end
                blink_count = cnt[1:0];
                r.event_status = EV_CURSOR;
            end
            default: begin
            end
        endcase

        mode = reg_view(R_CSTART) & CURSOR_MODE_MASK;
        if (mode == CURSOR_MODE_OFF) begin
            r.cursor_visible = 1'b0;
        end else if (mode == CURSOR_MODE_FAST || mode == CURSOR_MODE_SLOW) begin
            r.cursor_visible = blink_phase;
        end else begin
            r.cursor_visible = 1'b1;
        end
        wide = {reg_view(R_CA_HI), reg_view(R_CA_LO)};
        r.cursor_address = wide[13:0];
        r.cursor_top_line = 5'(reg_view(R_CSTART) & 8'h1F);
        r.cursor_bottom_line = 5'(reg_view(R_CEND) & 8'h1F);
        r.char_columns = reg_view(R_HDISP);
        r.char_height = 6'(reg_view(R_MAXSCAN) & 8'h1F) + 6'd1;
        r.char_rows = 7'(reg_view(R_VDISP) & 8'h7F);
        wide = {reg_view(R_SA_HI), reg_view(R_SA_LO)};
        r.start_address = wide[13:0];
        h = int'(reg_view(R_HTOTAL)) + 1 - int'(reg_view(R_HSYNC));
        r.hsync_distance = h[9:0];
        v = int'(reg_view(R_VTOTAL)) + 1 - int'(reg_view(R_VSYNC));
        r.vsync_distance = v[8:0];
        r.pad = 1'b0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: predict on each accepted beat, then offer the next one
    always @(posedge aclk) begin
        bus_access_t taken;
        bus_access_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                taken.cmd = s_tuser[1:0];
                taken.port = s_tuser[2];
                taken.data = s_tdata;
                status_q.push_back(predict_status(taken));
            end
            if (!s_tvalid || s_tready) begin
                if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = access_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tuser <= {nxt.port, nxt.cmd};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        crtc_status_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("read_data", want.read_data, m_tdata[7:0]);
                    check_field("event_status", want.event_status, m_tuser);
                    check_field("cursor_visible", want.cursor_visible, m_tdata[8]);
                    check_field("cursor_address", want.cursor_address, m_tdata[22:9]);
                    check_field("cursor_top_line", want.cursor_top_line, m_tdata[27:23]);
                    check_field("cursor_bottom_line", want.cursor_bottom_line,
                                m_tdata[32:28]);
                    check_field("char_columns", want.char_columns, m_tdata[40:33]);
                    check_field("char_height", want.char_height, m_tdata[46:41]);
                    check_field("char_rows", want.char_rows, m_tdata[53:47]);
                    check_field("start_address", want.start_address, m_tdata[67:54]);
                    check_field("hsync_distance", want.hsync_distance, m_tdata[77:68]);
                    check_field("vsync_distance", want.vsync_distance, m_tdata[86:78]);
                    check_field("pad", want.pad, m_tdata[87]);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("crt_controller_register_file_core_tb failed");
            $finish;
        end
    end

    task automatic push_beat(input logic [1:0] cmd, input logic port, input logic [7:0] data);
        bus_access_t a;
        a.cmd = cmd;
        a.port = port;
        a.data = data;
        access_q.push_back(a);
    endtask

    task automatic wait_idle();
        while (access_q.size() != 0 || s_tvalid || status_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_chip(input logic chip);
        cfg_we <= 1'b1;
        cfg_wdata <= chip;
        @(posedge aclk);
        chip_copy = chip;
        cfg_we <= 1'b0;
    endtask

    // Mostly index-then-data sequences, with ticks and some noise mixed in
    task automatic queue_random(input int total);
        int made;
        int pick;
        int k;
        logic [1:0] cmd;
        logic [7:0] idx;
        made = 0;
        while (made < total) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    idx = 8'($urandom_range(0, R_LAST));
                end else if (pick < 85) begin
                    idx = 8'($urandom_range(R_LAST + 1, 31));
                end else begin
                    idx = 8'($urandom_range(0, 255));
                end
                push_beat(CMD_WRITE, PORT_INDEX, idx);
                k = $urandom_range(1, 3);
                repeat (k) begin
                    cmd = ($urandom_range(0, 99) < 70) ? CMD_WRITE : CMD_READ;
                    push_beat(cmd, PORT_DATA, 8'($urandom));
                end
                made += k + 1;
            end else if (pick < 80) begin
                k = $urandom_range(1, 4);
                repeat (k) push_beat(CMD_TICK, 1'($urandom), 8'($urandom));
                made += k;
            end else if (pick < 88) begin
                push_beat(CMD_READ, PORT_INDEX, 8'($urandom));
                made++;
            end else begin
                cmd = 2'($urandom_range(0, 3));
                push_beat(cmd, 1'($urandom), 8'($urandom));
                if (cmd != CMD_NONE) begin
                    made++;
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_chip(1'b0);

        push_beat(CMD_READ, PORT_INDEX, 8'h00);
        // Index past the register file: reads all ones, writes bounce
        push_beat(CMD_WRITE, PORT_INDEX, 8'hFF);
        push_beat(CMD_READ, PORT_DATA, 8'h00);
        push_beat(CMD_WRITE, PORT_DATA, 8'hA5);
        // Upper index bits ignored: lands on cursor address high
        push_beat(CMD_WRITE, PORT_INDEX, 8'h2E);
        push_beat(CMD_WRITE, PORT_DATA, 8'hFF);
        push_beat(CMD_READ, PORT_DATA, 8'h00);
        push_beat(CMD_WRITE, PORT_INDEX, 8'(R_HTOTAL));
        push_beat(CMD_WRITE, PORT_DATA, 8'hFF);
        push_beat(CMD_WRITE, PORT_INDEX, 8'(R_HSYNC));
        push_beat(CMD_WRITE, PORT_DATA, 8'h00);
        // Slow blink wraps after three ticks, fast after two
        push_beat(CMD_WRITE, PORT_INDEX, 8'(R_CSTART));
        push_beat(CMD_WRITE, PORT_DATA, CURSOR_MODE_SLOW);
        repeat (3) push_beat(CMD_TICK, PORT_INDEX, 8'h00);
        push_beat(CMD_WRITE, PORT_DATA, CURSOR_MODE_FAST | 8'h1F);
        push_beat(CMD_TICK, PORT_DATA, 8'hFF);
        push_beat(CMD_NONE, PORT_DATA, 8'hFF);
        push_beat(CMD_WRITE, PORT_INDEX, 8'(R_LAST));
        push_beat(CMD_WRITE, PORT_DATA, 8'hFF);
        push_beat(CMD_READ, PORT_DATA, 8'h00);
        push_beat(CMD_WRITE, PORT_INDEX, 8'(R_MAXSCAN));
        push_beat(CMD_WRITE, PORT_DATA, 8'hFF);
        wait_idle();

        set_chip(1'b1);
        queue_random(450);
        wait_idle();

        send_idle_pct = 84;
        recv_idle_pct = 30;
        set_chip(1'b0);
        queue_random(450);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_chip(1'b1);
        queue_random(450);
        wait_idle();

        set_chip(1'b0);
        queue_random(450);
        wait_idle();

        if (status_q.size() != 0) begin
            $error("%0d results never arrived", status_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("crt_controller_register_file_core_tb passed");
        end else begin
            $display("crt_controller_register_file_core_tb failed");
        end
        $finish;
    end

endmodule
